### hdl/adbm_pkg.sv
// Shared types, codes and lookup functions of the ADB mouse register device.
`default_nettype none
package adbm_pkg;

    typedef enum logic [2:0] {
        OP_MOTION  = 3'd0,
        OP_BUTTON  = 3'd1,
        OP_TALK0   = 3'd2,
        OP_TALK1   = 3'd3,
        OP_LISTEN3 = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_CLASS      = 2'd0,
        CFG_BUTTONS    = 2'd1,
        CFG_AXIS_BITS  = 2'd2,
        CFG_RESOLUTION = 2'd3
    } cfg_idx_t;

    localparam logic [7:0]  CMD_SET_ADDR     = 8'h00;
    localparam logic [7:0]  CMD_HANDLER_STD  = 8'h01;
    localparam logic [7:0]  CMD_HANDLER_EXT2 = 8'h02;
    localparam logic [7:0]  CMD_HANDLER_EXT4 = 8'h04;
    localparam logic [7:0]  CMD_MOVE_ADDR    = 8'hFE;
    localparam int          SRQ_BIT          = 5;
    localparam logic [7:0]  CLASS_TABLET     = 8'd0;
    localparam logic [7:0]  CLASS_MOUSE      = 8'd1;
    localparam logic [7:0]  HANDLER_STD      = 8'd1;
    localparam logic [3:0]  ADDR_RESET       = 4'd3;
    localparam logic [23:0] ACC_MAX          = 24'h7FFFFF;
    localparam logic [23:0] ACC_MIN          = 24'h800000;
    localparam int          QUEUE_DEPTH      = 2;

    typedef struct packed {
        logic        [7:0]  listen_lo;
        logic        [7:0]  listen_hi;
        logic        [3:0]  listen_len;
        logic               collision;
        logic               force_req;
        logic        [7:0]  button_bits;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
        logic signed [15:0] delta_y;
        logic signed [15:0] delta_x;
        op_t                op;
    } in_item_t;

    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [2:0]      last_idx;
        logic [3:0]      bus_address;
        logic            srq_enabled;
        logic [7:0]      handler_now;
    } reply_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } q_ctl_t;

    function automatic logic [3:0] eff_buttons(input logic [3:0] cnt);
        eff_buttons = (cnt > 4'd8) ? 4'd8 : cnt;
    endfunction

    function automatic logic [7:0] button_mask(input logic [3:0] nb);
        logic [8:0] m;
        m = (9'd1 << nb) - 9'd1;
        button_mask = m[7:0];
    endfunction

    function automatic logic [4:0] bits_for_buttons(input logic [3:0] nb);
        unique case (nb)
            4'd1, 4'd2: bits_for_buttons = 5'd7;
            4'd3, 4'd4: bits_for_buttons = 5'd10;
            4'd5, 4'd6: bits_for_buttons = 5'd13;
            4'd7, 4'd8: bits_for_buttons = 5'd16;
            default:    bits_for_buttons = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] bits_for_axis(input logic [4:0] ab);
        unique case (ab)
            5'd8, 5'd9, 5'd10:    bits_for_axis = 5'd10;
            5'd11, 5'd12, 5'd13:  bits_for_axis = 5'd13;
            5'd14, 5'd15, 5'd16:  bits_for_axis = 5'd16;
            default:              bits_for_axis = 5'd7;
        endcase
    endfunction

    function automatic logic [15:0] clamp_axis(input logic signed [23:0] v,
                                               input logic [4:0] ab);
        logic signed [23:0] hi;
        logic signed [23:0] lo;
        hi = (24'sd1 <<< (ab - 5'd1)) - 24'sd1;
        lo = ~hi;
        if (v > hi)
        begin
            clamp_axis = hi[15:0];
        end
        else if (v < lo)
        begin
            clamp_axis = lo[15:0];
        end
        else
        begin
            clamp_axis = v[15:0];
        end
    endfunction

endpackage
`default_nettype wire

### hdl/adbm_front.sv
// Front part: configuration registers, device state and reply building.
`default_nettype none
module adbm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire adbm_pkg::in_item_t item,
    output adbm_pkg::reply_t       reply,
    output logic                   push,
    input  wire adbm_pkg::q_ctl_t  q_ctl
);
    import adbm_pkg::*;

    logic [7:0]  class_reg;
    logic [3:0]  buttons_cfg_reg;
    logic [4:0]  axis_bits_reg;
    logic [15:0] res_reg;

    logic signed [23:0] accum_x_reg, accum_x_next;
    logic signed [23:0] accum_y_reg, accum_y_next;
    logic signed [15:0] abs_x_reg, abs_x_next;
    logic signed [15:0] abs_y_reg, abs_y_next;
    logic [7:0]  held_reg, held_next;
    logic        changed_reg, changed_next;
    logic [3:0]  address_reg, address_next;
    logic [7:0]  handler_reg, handler_next;
    logic        srq_reg, srq_next;

    logic        accept;
    logic [3:0]  nb;
    logic [3:0]  nb_pack;
    logic [4:0]  ab;
    logic [4:0]  tb_axis;
    logic [4:0]  tb_btn;
    logic [4:0]  tb;
    logic [1:0]  nn;
    logic signed [24:0] sum_x, sum_y;
    logic signed [23:0] sat_x, sat_y;
    logic [15:0] yv, xv;
    logic        tablet;
    logic        report;
    logic [7:0][7:0] talk0_bytes;

    assign cfg_ready  = 1'b1;
    assign item_ready = q_ctl.ready;
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg       <= CLASS_MOUSE;
            buttons_cfg_reg <= 4'd1;
            axis_bits_reg   <= 5'd7;
            res_reg         <= 16'd300;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CLASS:      class_reg       <= cfg_data[7:0];
                CFG_BUTTONS:    buttons_cfg_reg <= cfg_data[3:0];
                CFG_AXIS_BITS:  axis_bits_reg   <= cfg_data[4:0];
                CFG_RESOLUTION: res_reg         <= cfg_data;
                default:        res_reg         <= res_reg;
            endcase
        end
    end

    always_comb
    begin
        nb      = eff_buttons(buttons_cfg_reg);
        nb_pack = (nb == 4'd0) ? 4'd1 : nb;
        if (axis_bits_reg < 5'd7)
        begin
            ab = 5'd7;
        end
        else if (axis_bits_reg > 5'd16)
        begin
            ab = 5'd16;
        end
        else
        begin
            ab = axis_bits_reg;
        end
        tb_axis = bits_for_axis(ab);
        tb_btn  = bits_for_buttons(nb_pack);
        tb      = (tb_btn > tb_axis) ? tb_btn : tb_axis;
        case (tb)
            5'd10:   nn = 2'd1;
            5'd13:   nn = 2'd2;
            5'd16:   nn = 2'd3;
            default: nn = 2'd0;
        endcase
        tablet = (class_reg == CLASS_TABLET);
        yv = clamp_axis(tablet ? 24'(abs_y_reg) : accum_y_reg, ab);
        xv = clamp_axis(tablet ? 24'(abs_x_reg) : accum_x_reg, ab);
        talk0_bytes    = '0;
        talk0_bytes[0] = {~held_reg[0], yv[6:0]};
        talk0_bytes[1] = {~held_reg[1], xv[6:0]};
        talk0_bytes[2] = {~held_reg[2], yv[9:7], ~held_reg[3], xv[9:7]};
        talk0_bytes[3] = {~held_reg[4], yv[12:10], ~held_reg[5], xv[12:10]};
        talk0_bytes[4] = {~held_reg[6], yv[15:13], ~held_reg[7], xv[15:13]};
        report = (accum_x_reg != 24'sd0) || (accum_y_reg != 24'sd0) || changed_reg
                 || item.force_req;

        sum_x = 25'(accum_x_reg) + 25'(item.delta_x);
        sum_y = 25'(accum_y_reg) + 25'(item.delta_y);
        sat_x = (sum_x[24] != sum_x[23]) ? (sum_x[24] ? ACC_MIN : ACC_MAX) : sum_x[23:0];
        sat_y = (sum_y[24] != sum_y[23]) ? (sum_y[24] ? ACC_MIN : ACC_MAX) : sum_y[23:0];
    end

    always_comb
    begin
        accum_x_next = accum_x_reg;
        accum_y_next = accum_y_reg;
        abs_x_next   = abs_x_reg;
        abs_y_next   = abs_y_reg;
        held_next    = held_reg;
        changed_next = changed_reg;
        address_next = address_reg;
        handler_next = handler_reg;
        srq_next     = srq_reg;
        push         = 1'b0;
        reply.bytes       = talk0_bytes;
        reply.last_idx    = 3'd1 + 3'(nn);
        reply.bus_address = address_reg;
        reply.srq_enabled = srq_reg;
        reply.handler_now = handler_reg;
        if (class_reg == CLASS_MOUSE && handler_reg == HANDLER_STD)
        begin
            reply.last_idx = 3'd1;
        end
        if (accept)
        begin
            unique case (item.op)
                OP_MOTION:
                begin
                    accum_x_next = sat_x;
                    accum_y_next = sat_y;
                    abs_x_next   = item.pos_x;
                    abs_y_next   = item.pos_y;
                    if (tablet)
                    begin
                        changed_next = 1'b1;
                    end
                end
                OP_BUTTON:
                begin
                    held_next    = item.button_bits & button_mask(nb);
                    abs_x_next   = item.pos_x;
                    abs_y_next   = item.pos_y;
                    changed_next = 1'b1;
                end
                OP_TALK0:
                begin
                    if (report)
                    begin
                        push         = 1'b1;
                        accum_x_next = '0;
                        accum_y_next = '0;
                        changed_next = 1'b0;
                    end
                end
                OP_TALK1:
                begin
                    push           = 1'b1;
                    reply.bytes    = {4'd0, buttons_cfg_reg, class_reg, res_reg[7:0],
                                      res_reg[15:8], "l", "p", "p", "a"};
                    reply.last_idx = 3'd7;
                end
                OP_LISTEN3:
                begin
                    if (item.listen_len >= 4'd2)
                    begin
                        case (item.listen_lo)
                            CMD_SET_ADDR:
                            begin
                                address_next = item.listen_hi[3:0];
                                srq_next     = item.listen_hi[SRQ_BIT];
                            end
                            CMD_HANDLER_STD, CMD_HANDLER_EXT2, CMD_HANDLER_EXT4:
                            begin
                                handler_next = item.listen_lo;
                            end
                            CMD_MOVE_ADDR:
                            begin
                                if (!item.collision)
                                begin
                                    address_next = item.listen_hi[3:0];
                                end
                            end
                            default:
                            begin
                                handler_next = handler_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_x_reg <= '0;
            accum_y_reg <= '0;
            abs_x_reg   <= '0;
            abs_y_reg   <= '0;
            held_reg    <= '0;
            changed_reg <= 1'b0;
            address_reg <= ADDR_RESET;
            handler_reg <= HANDLER_STD;
            srq_reg     <= 1'b1;
        end
        else
        begin
            accum_x_reg <= accum_x_next;
            accum_y_reg <= accum_y_next;
            abs_x_reg   <= abs_x_next;
            abs_y_reg   <= abs_y_next;
            held_reg    <= held_next;
            changed_reg <= changed_next;
            address_reg <= address_next;
            handler_reg <= handler_next;
            srq_reg     <= srq_next;
        end
    end

endmodule
`default_nettype wire

### hdl/adbm_queue.sv
// Short queue of pending reply descriptors between front and back parts.
`default_nettype none
module adbm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire adbm_pkg::reply_t  wr_data,
    input  wire logic              pop,
    output adbm_pkg::reply_t       rd_data,
    output adbm_pkg::q_ctl_t       q_ctl
);
    import adbm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    reply_t entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;

    assign q_ctl.valid = (fill_reg != '0);
    assign q_ctl.ready = (fill_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign rd_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

### hdl/adbm_back.sv
// Back part: sends the queued reply bytes, one per cycle while m_tready is high, through an output register.
`default_nettype none
module adbm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire adbm_pkg::reply_t  head,
    input  wire adbm_pkg::q_ctl_t  q_ctl,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,
    output logic                   m_tlast
);
    import adbm_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [23:0] data_reg;
    logic        last_reg;
    logic        load;
    logic        is_last;

    assign load    = q_ctl.valid && (!valid_reg || m_tready);
    assign is_last = (idx_reg == head.last_idx);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {3'd0, head.handler_now, head.srq_enabled, head.bus_address,
                         head.bytes[idx_reg]};
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

### hdl/adb_mouse_register_device.sv
// Top level of the ADB mouse and tablet register device.
//
// Host events and bus commands arrive as words on the s_ channel; the op code
// rides in s_tuser. Motion, button and listen words update the device state and
// give no reply. A talk of register 0 (when there is something to report, or on
// force) gives 2 to 5 reply words; a talk of register 1 gives 8. Each reply word
// carries one byte with the current bus address, SRQ enable and handler ID, and
// m_tlast marks the final byte of a reply.
// The front accepts one word per cycle while the queue is not full and updates
// state in that cycle; a reply enters a two-entry queue and its first word passes
// through the output register to m_. The back sends one reply byte per cycle
// while m_tready is high; the output port sets the sustained rate.
// When m_tready is low the output register holds its word; once the queue is
// full, s_tready drops until a reply drains. Event and listen words never wait
// for the queue to empty unless it is full.
// Configuration writes on cfg_ are taken in every cycle while the block is idle.
// Reset clears the queue and the output, and sets the registers and device state
// to their defaults: mouse class, one button, 7-bit axes, 300 units per inch,
// address 3, handler 1, SRQ enabled.
`default_nettype none
module adb_mouse_register_device (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // delta_x, delta_y, pos_x, pos_y, button_bits, force_req, listen_len,
    // listen_hi, listen_lo, collision, zero fill
    input  wire logic [95:0] s_tdata,
    // op
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // data_byte, bus_address, srq_enabled, handler_now, zero fill
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);
    import adbm_pkg::*;

    in_item_t item;
    reply_t   wr_reply;
    reply_t   head;
    q_ctl_t   q_ctl;
    logic     push;
    logic     pop;

    assign item.op          = op_t'(s_tuser);
    assign item.delta_x     = s_tdata[15:0];
    assign item.delta_y     = s_tdata[31:16];
    assign item.pos_x       = s_tdata[47:32];
    assign item.pos_y       = s_tdata[63:48];
    assign item.button_bits = s_tdata[71:64];
    assign item.force_req   = s_tdata[72];
    assign item.listen_len  = s_tdata[76:73];
    assign item.listen_hi   = s_tdata[84:77];
    assign item.listen_lo   = s_tdata[92:85];
    assign item.collision   = s_tdata[93];

    adbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .reply      (wr_reply),
        .push       (push),
        .q_ctl      (q_ctl)
    );

    adbm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_reply),
        .pop     (pop),
        .rd_data (head),
        .q_ctl   (q_ctl)
    );

    adbm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_ctl    (q_ctl),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
